### rtl/core/gcd_pkg.sv
// Shared constants, widths and the arctangent table of the great-circle distance unit.
package gcd_pkg;

  localparam int unsigned LAT_W    = 24;
  localparam int unsigned LON_W    = 25;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 25;

  // Angles inside the datapath are degrees * 2^17, signed.
  localparam int unsigned ANG_W = 27;
  localparam logic signed [ANG_W-1:0] CIRCLE_C  = 27'sd47185920;
  localparam logic signed [ANG_W-1:0] HALF_C    = 27'sd23592960;
  localparam logic signed [ANG_W-1:0] QUARTER_C = 27'sd11796480;
  localparam int unsigned MAG_W = 24;

  localparam int unsigned DEG_RAD_W = 27;
  localparam logic [DEG_RAD_W-1:0] DEG_TO_RAD_Q32 = 27'd74961321;
  // Binary point of the degree product before rounding to radians.
  localparam int unsigned DEG_RAD_SHIFT = 49;

  localparam int unsigned XY_W = 32;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sh26DD3B6A;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

  localparam int unsigned SQRT_STEPS  = 31;
  localparam int unsigned SQRT_ROOT_W = 31;
  localparam int unsigned SQRT_REM_W  = 32;
  localparam int unsigned SQRT_IN_W   = 62;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378160;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 25'd26353664;

  // atan(2^-i) in Q30, truncated; entries 27 to 30 rounded to nearest
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/gcd_in_if.sv
// Input channel: one pair of points per item.
interface gcd_in_if;
  logic valid;
  logic ready;
  logic signed [gcd_pkg::LAT_W-1:0] lat_a;
  logic signed [gcd_pkg::LON_W-1:0] lon_a;
  logic signed [gcd_pkg::LAT_W-1:0] lat_b;
  logic signed [gcd_pkg::LON_W-1:0] lon_b;

  modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                  input ready);
  modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                output ready);
endinterface

### rtl/core/gcd_out_if.sv
// Output channel: one distance per item.
interface gcd_out_if;
  logic valid;
  logic ready;
  logic [gcd_pkg::DIST_W-1:0] distance_m;

  modport source (output valid, output distance_m, input ready);
  modport sink (input valid, input distance_m, output ready);
endinterface

### rtl/core/great_circle_distance_unit.sv
// Top level of the great-circle distance unit: haversine over pipelined CORDIC cells.
//
//   channel     | dir | handshake          | payload
//   in_chan_i   | in  | valid/ready        | lat_a, lon_a, lat_b, lon_b
//   out_chan_o  | out | valid/ready        | distance_m
//   cfg_we_i    | in  | write enable only  | cfg_wdata_i = sphere_radius_m
//
// One item per cycle unless the output stalls; the pipeline depth is set by the two CORDIC
// chains (one cell per step) and the 31-digit square-root chain.
// Reset clears the valid line and loads the radius with 6378160 m.
// The whole pipeline advances together; it holds only while the output
// register carries an item that has not been taken.
module great_circle_distance_unit #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gcd_in_if.sink                           in_chan_i,
  gcd_out_if.source                        out_chan_o,
  input  logic                             cfg_we_i,
  input  logic [gcd_pkg::RADIUS_W-1:0]     cfg_wdata_i
);

  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned F      = ANGLE_FRAC_BITS;
  localparam int unsigned ZW     = F + 4;
  localparam int unsigned L      = 2 * N + 40;
  localparam int unsigned AW     = F + 1;
  localparam int unsigned PROD_W = gcd_pkg::RADIUS_W + AW;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned XW     = gcd_pkg::XY_W;
  localparam int unsigned AN     = gcd_pkg::ANG_W;

  // Advance everything unless a finished item is stuck at the output.
  logic en;
  logic [L-1:0] vld_q;
  logic [gcd_pkg::RADIUS_W-1:0] radius_q;

  assign en = !vld_q[L-1] || out_chan_o.ready;
  assign in_chan_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_chan_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // Stage 0: half differences and doubled latitudes, all in degrees * 2^17.
  logic signed [AN-1:0] ang_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= AN'(in_chan_i.lat_a) - AN'(in_chan_i.lat_b);
      ang_q[1] <= AN'(in_chan_i.lon_a) - AN'(in_chan_i.lon_b);
      ang_q[2] <= AN'(in_chan_i.lat_a) <<< 1;
      ang_q[3] <= AN'(in_chan_i.lat_b) <<< 1;
    end
  end

  // Four sine/cosine lanes: folding, then one rotation cell per step.
  logic signed [XW-1:0] rx [4][N+1];
  logic signed [XW-1:0] ry [4][N+1];
  logic signed [ZW-1:0] rz [4][N+1];
  logic                 negcos [4];
  logic [3:0]           nc_q [N];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    gcd_angle_prep #(.ANGLE_FRAC_BITS(F), .ZW(ZW)) u_prep (
      .clk_i    (clk_i),
      .en_i     (en),
      .angle_i  (ang_q[l]),
      .z_o      (rz[l][0]),
      .negcos_o (negcos[l])
    );
    assign rx[l][0] = gcd_pkg::GAIN_Q30;
    assign ry[l][0] = '0;
    for (genvar s = 0; s < N; s++) begin : g_step
      gcd_cordic_cell #(
        .STEP(s), .ANGLE_FRAC_BITS(F), .ZW(ZW), .VECTORING(1'b0)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][s]),
        .y_i   (ry[l][s]),
        .z_i   (rz[l][s]),
        .x_o   (rx[l][s+1]),
        .y_o   (ry[l][s+1]),
        .z_o   (rz[l][s+1])
      );
    end
  end

  // Carry the cosine sign flags alongside the rotation cells.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nc_q[0] <= {negcos[3], negcos[2], negcos[1], negcos[0]};
      for (int i = 1; i < N; i++) nc_q[i] <= nc_q[i-1];
    end
  end

  // Haversine term: squares and the cosine-weighted product, floored to Q30.
  logic signed [XW-1:0]   c1, c2;
  logic signed [2*XW-1:0] p_lat, p_lon, p_cc, p_term;
  logic signed [XW-1:0]   sq_lat_q, sq_lon_q, cc_q, sq_lat2_q, term_q;
  logic signed [32:0]     a_sum;
  logic [30:0]            a_d;

  always_comb begin
    c1     = nc_q[N-1][2] ? -rx[2][N] : rx[2][N];
    c2     = nc_q[N-1][3] ? -rx[3][N] : rx[3][N];
    p_lat  = ry[0][N] * ry[0][N];
    p_lon  = ry[1][N] * ry[1][N];
    p_cc   = c1 * c2;
    p_term = cc_q * sq_lon_q;
    a_sum  = 33'(sq_lat2_q) + 33'(term_q);
    // clamp to [0, 1]
    if (a_sum[32]) a_d = '0;
    else if (a_sum > gcd_pkg::ONE_Q30) a_d = gcd_pkg::ONE_Q30[30:0];
    else a_d = a_sum[30:0];
  end

  logic [gcd_pkg::SQRT_IN_W-1:0]   sn  [2][gcd_pkg::SQRT_STEPS+1];
  logic [gcd_pkg::SQRT_REM_W-1:0]  srm [2][gcd_pkg::SQRT_STEPS+1];
  logic [gcd_pkg::SQRT_ROOT_W-1:0] srt [2][gcd_pkg::SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_lat_q  <= XW'(p_lat >>> 30);
      sq_lon_q  <= XW'(p_lon >>> 30);
      cc_q      <= XW'(p_cc >>> 30);
      sq_lat2_q <= sq_lat_q;
      term_q    <= XW'(p_term >>> 30);
      sn[0][0]  <= {1'b0, a_d, 30'd0};
      sn[1][0]  <= {1'b0, gcd_pkg::ONE_Q30[30:0] - a_d, 30'd0};
    end
  end

  // Square roots of a and 1 - a, one result bit per cell.
  for (genvar q = 0; q < 2; q++) begin : g_sqrt
    assign srm[q][0] = '0;
    assign srt[q][0] = '0;
    for (genvar k = 0; k < gcd_pkg::SQRT_STEPS; k++) begin : g_digit
      gcd_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .n_i    (sn[q][k]),
        .rem_i  (srm[q][k]),
        .root_i (srt[q][k]),
        .n_o    (sn[q][k+1]),
        .rem_o  (srm[q][k+1]),
        .root_o (srt[q][k+1])
      );
    end
  end

  // Central half-angle: vectoring cells on (sqrt(1-a), sqrt(a)).
  logic signed [XW-1:0] vx [N+1];
  logic signed [XW-1:0] vy [N+1];
  logic signed [ZW-1:0] vz [N+1];

  assign vx[0] = XW'(srt[1][gcd_pkg::SQRT_STEPS]);
  assign vy[0] = XW'(srt[0][gcd_pkg::SQRT_STEPS]);
  assign vz[0] = '0;

  for (genvar s = 0; s < N; s++) begin : g_vec
    gcd_cordic_cell #(
      .STEP(s), .ANGLE_FRAC_BITS(F), .ZW(ZW), .VECTORING(1'b1)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[s]),
      .y_i   (vy[s]),
      .z_i   (vz[s]),
      .x_o   (vx[s+1]),
      .y_o   (vy[s+1]),
      .z_o   (vz[s+1])
    );
  end

  // Scale by the radius, round to whole metres and saturate.
  logic [AW-1:0]     ang;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  rnd;
  logic [SUM_W-F-1:0] metres;
  logic [gcd_pkg::DIST_W-1:0] dist_d, dist_q;

  always_comb begin
    ang    = vz[N][ZW-1] ? '0 : vz[N][AW-1:0];
    rnd    = SUM_W'({prod_q, 1'b0}) + (SUM_W'(1) << (F - 1));
    metres = rnd[SUM_W-1:F];
    if (metres > (SUM_W-F)'(gcd_pkg::DIST_MAX)) dist_d = gcd_pkg::DIST_MAX;
    else dist_d = metres[gcd_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PROD_W'(radius_q) * PROD_W'(ang);
      dist_q <= dist_d;
    end
  end

  assign out_chan_o.valid      = vld_q[L-1];
  assign out_chan_o.distance_m = dist_q;

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_chan_i.ready == (!out_chan_o.valid || out_chan_o.ready))
    else $error("input ready does not follow output stall");

  a_distance_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid |-> out_chan_o.distance_m <= gcd_pkg::DIST_MAX)
    else $error("distance above saturation limit");

  a_item_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_chan_i.ready) |=> vld_q[0])
    else $error("accepted item missing from first stage");
`endif

endmodule

### rtl/core/gcd_angle_prep.sv
// Angle folding into a quarter turn and conversion to fixed-point radians, three stages.
module gcd_angle_prep #(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned ZW = 20
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gcd_pkg::ANG_W-1:0]    angle_i,
  output logic signed [ZW-1:0]                z_o,
  output logic                                negcos_o
);

  localparam int unsigned SH     = gcd_pkg::DEG_RAD_SHIFT - ANGLE_FRAC_BITS;
  localparam int unsigned PROD_W = gcd_pkg::MAG_W + gcd_pkg::DEG_RAD_W;
  localparam int unsigned RND_W  = PROD_W + 1;

  logic signed [gcd_pkg::ANG_W-1:0] r_wrap, r_fold;
  logic                             fold_neg;
  logic [gcd_pkg::MAG_W-1:0]        mag_d, mag_q;
  logic                             neg_q, nc1_q, neg2_q, nc2_q;
  logic [PROD_W-1:0]                prod_q;
  logic [RND_W-1:0]                 rnd, shd;
  logic [ZW-1:0]                    zmag;

  always_comb begin
    r_wrap = angle_i;
    if (r_wrap >= gcd_pkg::HALF_C) r_wrap = r_wrap - gcd_pkg::CIRCLE_C;
    if (r_wrap < -gcd_pkg::HALF_C) r_wrap = r_wrap + gcd_pkg::CIRCLE_C;
    r_fold   = r_wrap;
    fold_neg = 1'b0;
    if (r_wrap > gcd_pkg::QUARTER_C) begin
      r_fold   = gcd_pkg::HALF_C - r_wrap;
      fold_neg = 1'b1;
    end else if (r_wrap < -gcd_pkg::QUARTER_C) begin
      r_fold   = -gcd_pkg::HALF_C - r_wrap;
      fold_neg = 1'b1;
    end
    mag_d = r_fold[gcd_pkg::ANG_W-1] ? gcd_pkg::MAG_W'(-r_fold) : gcd_pkg::MAG_W'(r_fold);
  end

  // round half away from zero on the magnitude
  always_comb begin
    rnd  = RND_W'(prod_q) + (RND_W'(1) << (SH - 1));
    shd  = rnd >> SH;
    zmag = shd[ZW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= mag_d;
      neg_q    <= r_fold[gcd_pkg::ANG_W-1];
      nc1_q    <= fold_neg;
      prod_q   <= PROD_W'(mag_q) * PROD_W'(gcd_pkg::DEG_TO_RAD_Q32);
      neg2_q   <= neg_q;
      nc2_q    <= nc1_q;
      z_o      <= neg2_q ? -zmag : zmag;
      negcos_o <= nc2_q;
    end
  end

endmodule

### rtl/core/gcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
module gcd_cordic_cell #(
  parameter int unsigned STEP = 0,
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned ZW = 20,
  parameter bit VECTORING = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [gcd_pkg::XY_W-1:0]   x_i,
  input  logic signed [gcd_pkg::XY_W-1:0]   y_i,
  input  logic signed [ZW-1:0]              z_i,
  output logic signed [gcd_pkg::XY_W-1:0]   x_o,
  output logic signed [gcd_pkg::XY_W-1:0]   y_o,
  output logic signed [ZW-1:0]              z_o
);

  localparam logic [31:0] ATAN_Q30 = gcd_pkg::atan_q30(STEP[4:0]);
  localparam logic [31:0] ATAN_SH  = ATAN_Q30 >> (30 - ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_SH);

  logic signed [gcd_pkg::XY_W-1:0] dx, dy;
  logic                            up;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    up = VECTORING ? y_i[gcd_pkg::XY_W-1] : ~z_i[ZW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (up) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ATAN;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ATAN;
      end
    end
  end

endmodule

### rtl/core/gcd_sqrt_cell.sv
// One digit of a restoring integer square root, registered.
module gcd_sqrt_cell (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [gcd_pkg::SQRT_IN_W-1:0]      n_i,
  input  logic [gcd_pkg::SQRT_REM_W-1:0]     rem_i,
  input  logic [gcd_pkg::SQRT_ROOT_W-1:0]    root_i,
  output logic [gcd_pkg::SQRT_IN_W-1:0]      n_o,
  output logic [gcd_pkg::SQRT_REM_W-1:0]     rem_o,
  output logic [gcd_pkg::SQRT_ROOT_W-1:0]    root_o
);

  localparam int unsigned RW = gcd_pkg::SQRT_REM_W;
  localparam int unsigned QW = gcd_pkg::SQRT_ROOT_W;
  localparam int unsigned NW = gcd_pkg::SQRT_IN_W;

  logic [RW+1:0] rem2, trial, diff;
  logic          fits;

  always_comb begin
    rem2  = {rem_i, n_i[NW-1:NW-2]};
    trial = (RW+2)'({root_i, 2'b01});
    fits  = rem2 >= trial;
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o <= {n_i[NW-3:0], 2'b00};
      if (fits) begin
        rem_o  <= diff[RW-1:0];
        root_o <= {root_i[QW-2:0], 1'b1};
      end else begin
        rem_o  <= rem2[RW-1:0];
        root_o <= {root_i[QW-2:0], 1'b0};
      end
    end
  end

endmodule
